// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the controller, the cell array and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Action codes carried by a request.
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_CHANGE  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the cell array.
  typedef struct packed {
    logic load;        // capture the request and clear the result fields
    logic match;       // register the key compare of every cell
    logic remove_head; // take the head out
    logic remove_key;  // take out the farthest matching entry
    logic insert;      // insert the captured entry in order
  } spq_cmd_t;

endpackage

// File: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences the match, remove and insert steps of one request.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        action,
  output logic              busy,
  output logic              done,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_REMOVE = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  // Next state: each action visits only the steps it needs.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = action;
          case (action)
            ACT_ENQUEUE: state_nxt = S_INSERT;
            ACT_DEQUEUE: state_nxt = S_REMOVE;
            ACT_CHANGE:  state_nxt = S_MATCH;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_MATCH:  state_nxt = S_REMOVE;
      S_REMOVE: state_nxt = (op_r == ACT_CHANGE) ? S_INSERT : S_DONE;
      S_INSERT: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= ACT_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Command decode.
  always_comb begin
    cmd.load        = (state_r == S_IDLE) && start;
    cmd.match       = (state_r == S_MATCH);
    cmd.remove_head = (state_r == S_REMOVE) && (op_r == ACT_DEQUEUE);
    cmd.remove_key  = (state_r == S_REMOVE) && (op_r == ACT_CHANGE);
    cmd.insert      = (state_r == S_INSERT);
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// File: rtl/spq_cells.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell array
// A row of entry cells kept in ascending priority order, head in cell zero.
// Each cell compares itself against the broadcast request and shifts.
// ----------------------------------------------------------------------------
module spq_cells #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spq_pkg::spq_cmd_t   cmd,
  input  logic signed [15:0]  node_x,
  input  logic signed [15:0]  node_y,
  input  logic [31:0]         new_priority,
  output logic                item_valid,
  output logic signed [15:0]  item_x,
  output logic signed [15:0]  item_y,
  output logic [31:0]         item_priority,
  output logic signed [15:0]  head_x,
  output logic signed [15:0]  head_y,
  output logic [31:0]         head_priority,
  output logic [6:0]          entry_count,
  output logic [1:0]          status
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [15:0] x_r [CAPACITY];
  logic signed [15:0] y_r [CAPACITY];
  logic [31:0]        p_r [CAPACITY];
  logic [CW-1:0]      count_r;

  logic signed [15:0] key_x_r, key_y_r;
  logic [31:0]        key_p_r;
  logic [CAPACITY-1:0] match_r;
  logic                item_valid_r;
  logic signed [15:0]  item_x_r, item_y_r;
  logic [31:0]         item_p_r;
  logic [1:0]          status_r;

  logic [CAPACITY-1:0] valid, gt, beyond;
  logic                found, full, empty;

  // Per-cell flags: occupancy, priority above the new one, and the
  // region from the farthest key match onwards.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (CW'(i) < count_r);
      gt[i]    = valid[i] && (p_r[i] > key_p_r);
    end
    beyond[CAPACITY-1] = 1'b1;
    for (int i = CAPACITY - 2; i >= 0; i--) begin
      beyond[i] = beyond[i+1] && !match_r[i+1];
    end
    found = |match_r;
    full  = (count_r == CW'(CAPACITY));
    empty = (count_r == '0);
  end

  // Cell storage: left shift on removal, right shift on insertion.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if ((cmd.remove_head && !empty) || (cmd.remove_key && found && beyond[i])) begin
        if (i < CAPACITY - 1) begin
          x_r[i] <= x_r[(i < CAPACITY - 1) ? i + 1 : i];
          y_r[i] <= y_r[(i < CAPACITY - 1) ? i + 1 : i];
          p_r[i] <= p_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end else if (cmd.insert && !full) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          x_r[i] <= x_r[(i > 0) ? i - 1 : 0];
          y_r[i] <= y_r[(i > 0) ? i - 1 : 0];
          p_r[i] <= p_r[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || (CW'(i) == count_r)) begin
          x_r[i] <= key_x_r;
          y_r[i] <= key_y_r;
          p_r[i] <= key_p_r;
        end
      end
    end
  end

  // Request capture, match vector and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_x_r <= node_x;
      key_y_r <= node_y;
      key_p_r <= new_priority;
      item_x_r <= '0;
      item_y_r <= '0;
      item_p_r <= '0;
    end else if (cmd.remove_head && !empty) begin
      item_x_r <= x_r[0];
      item_y_r <= y_r[0];
      item_p_r <= p_r[0];
    end
    if (cmd.match) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= valid[i] && (x_r[i] == key_x_r) && (y_r[i] == key_y_r);
      end
    end else if (cmd.load) begin
      match_r <= '0;
    end
  end

  // Control state: fill count, status and item flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      status_r     <= ST_OK;
      item_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        status_r     <= ST_OK;
        item_valid_r <= 1'b0;
      end
      if (cmd.remove_head) begin
        if (empty) begin
          status_r <= ST_EMPTY;
        end else begin
          item_valid_r <= 1'b1;
          count_r      <= count_r - 1'b1;
        end
      end else if (cmd.remove_key && found) begin
        count_r <= count_r - 1'b1;
      end else if (cmd.insert) begin
        if (full) begin
          status_r <= ST_FULL;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  assign item_valid    = item_valid_r;
  assign item_x        = item_x_r;
  assign item_y        = item_y_r;
  assign item_priority = item_p_r;
  assign head_x        = empty ? 16'sd0 : x_r[0];
  assign head_y        = empty ? 16'sd0 : y_r[0];
  assign head_priority = empty ? 32'd0 : p_r[0];
  assign entry_count   = 7'(count_r);
  assign status        = status_r;

endmodule

// File: rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Min-priority queue as a sorted row of cells with change-priority.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An enqueue runs
// the insert step, a dequeue the remove step, a change-priority the key
// compare, remove and insert steps in that order, and the unused action
// none of them; every action ends with the step in which the result is
// shown, and busy falls in the cycle after. The steps are the broadcast
// key compare, the shift that removes an entry, the shift that inserts
// and the result step. The result is on the out_ ports for one cycle
// only and cannot be held off, so the receiver must take it then.
module sorted_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_node_x,
  input  logic signed [15:0] in_node_y,
  input  logic [31:0]        in_new_priority,
  output logic               out_valid,
  output logic               out_item_valid,
  output logic signed [15:0] out_item_x,
  output logic signed [15:0] out_item_y,
  output logic [31:0]        out_item_priority,
  output logic signed [15:0] out_head_x,
  output logic signed [15:0] out_head_y,
  output logic [31:0]        out_head_priority,
  output logic [6:0]         out_entry_count,
  output logic [1:0]         out_status
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // Step sequencer.
  spq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .busy   (busy),
    .done   (out_valid),
    .cmd    (cmd)
  );

  // Cell array and result fields.
  spq_cells #(.CAPACITY(CAPACITY)) u_cells (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .node_x        (in_node_x),
    .node_y        (in_node_y),
    .new_priority  (in_new_priority),
    .item_valid    (out_item_valid),
    .item_x        (out_item_x),
    .item_y        (out_item_y),
    .item_priority (out_item_priority),
    .head_x        (out_head_x),
    .head_y        (out_head_y),
    .head_priority (out_head_priority),
    .entry_count   (out_entry_count),
    .status        (out_status)
  );

endmodule

// File: rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on request sequencing and result consistency.
// ----------------------------------------------------------------------------
module spq_assertions (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_item_valid,
  input logic [1:0] out_status
);
  import spq_pkg::*;

  // A result is only shown while a request is in progress.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but not busy");

  // The block is free again straight after a result.
  a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("still busy after result");

  // A returned entry always comes with an ok status.
  a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_valid) |-> (out_status == ST_OK))
    else $error("entry returned with error status");

endmodule

bind sorted_priority_queue_core spq_assertions u_spq_assertions (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_item_valid (out_item_valid),
  .out_status     (out_status)
);

// File: dv/spq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches requests and results of the queue core, predicts every result from
// a sorted-array model of its own and compares each result field by field.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_node_x,
  input  logic signed [15:0] in_node_y,
  input  logic [31:0]        in_new_priority,
  input  logic               out_valid,
  input  logic               out_item_valid,
  input  logic signed [15:0] out_item_x,
  input  logic signed [15:0] out_item_y,
  input  logic [31:0]        out_item_priority,
  input  logic signed [15:0] out_head_x,
  input  logic signed [15:0] out_head_y,
  input  logic [31:0]        out_head_priority,
  input  logic [6:0]         out_entry_count,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending_count
);
  import spq_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] pri;
  } entry_t;

  typedef struct packed {
    logic        item_valid;
    logic [15:0] item_x;
    logic [15:0] item_y;
    logic [31:0] item_priority;
    logic [15:0] head_x;
    logic [15:0] head_y;
    logic [31:0] head_priority;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } result_t;

  entry_t  open_list[$];
  result_t expected_results[$];

  // Stable ordered insert: the new entry goes after every entry of equal or
  // lower priority.
  function automatic logic [1:0] insert_sorted(entry_t e);
    int pos;
    pos = 0;
    if (open_list.size() >= CAPACITY) return ST_FULL;
    while (pos < open_list.size() && open_list[pos].pri <= e.pri) pos++;
    open_list.insert(pos, e);
    return ST_OK;
  endfunction

  function automatic result_t predict_step(logic [1:0] act, entry_t e);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_ENQUEUE: begin
        r.status = insert_sorted(e);
      end
      ACT_DEQUEUE: begin
        if (open_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.item_valid    = 1'b1;
          r.item_x        = open_list[0].x;
          r.item_y        = open_list[0].y;
          r.item_priority = open_list[0].pri;
          open_list.delete(0);
        end
      end
      ACT_CHANGE: begin
        // The matching entry farthest from the head is the one removed.
        for (int k = open_list.size() - 1; k >= 0; k--) begin
          if (open_list[k].x == e.x && open_list[k].y == e.y) begin
            open_list.delete(k);
            break;
          end
        end
        r.status = insert_sorted(e);
      end
      default: ;
    endcase
    if (open_list.size() > 0) begin
      r.head_x        = open_list[0].x;
      r.head_y        = open_list[0].y;
      r.head_priority = open_list[0].pri;
    end
    r.entry_count = 7'(open_list.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    result_t want;
    entry_t  e;
    if (!rst_n) begin
      open_list.delete();
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_valid !== want.item_valid)
            report_mismatch("item_valid", out_item_valid, want.item_valid);
          if (out_item_x !== want.item_x)
            report_mismatch("item_x", out_item_x, want.item_x);
          if (out_item_y !== want.item_y)
            report_mismatch("item_y", out_item_y, want.item_y);
          if (out_item_priority !== want.item_priority)
            report_mismatch("item_priority", out_item_priority, want.item_priority);
          if (out_head_x !== want.head_x)
            report_mismatch("head_x", out_head_x, want.head_x);
          if (out_head_y !== want.head_y)
            report_mismatch("head_y", out_head_y, want.head_y);
          if (out_head_priority !== want.head_priority)
            report_mismatch("head_priority", out_head_priority, want.head_priority);
          if (out_entry_count !== want.entry_count)
            report_mismatch("entry_count", out_entry_count, want.entry_count);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
        end
      end
      if (start && !busy) begin
        e.x   = in_node_x;
        e.y   = in_node_y;
        e.pri = in_new_priority;
        expected_results.push_back(predict_step(in_action, e));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives directed and random requests into the queue core under several
// sender idling phases; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_action = ACT_NONE;
  logic signed [15:0] in_node_x = '0;
  logic signed [15:0] in_node_y = '0;
  logic [31:0]        in_new_priority = '0;
  logic               out_valid;
  logic               out_item_valid;
  logic signed [15:0] out_item_x;
  logic signed [15:0] out_item_y;
  logic [31:0]        out_item_priority;
  logic signed [15:0] out_head_x;
  logic signed [15:0] out_head_y;
  logic [31:0]        out_head_priority;
  logic [6:0]         out_entry_count;
  logic [1:0]         out_status;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count = 0;
  int                 idle_pct = 0;

  // Small key pool so that change-priority often finds a match.
  logic [15:0] key_pool[8];

  always #5 clk = ~clk;

  sorted_priority_queue_core #(.CAPACITY(CAPACITY)) u_top (.*);

  spq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_priority_queue_core regression: fail");
      $finish;
    end
  end

  // Issue one request and hold it until it is accepted. Busy only moves at
  // the rising edge, so its value at a falling edge tells whether the next
  // rising edge takes the request.
  task automatic send_request(logic [1:0] act, logic [15:0] x, logic [15:0] y,
                              logic [31:0] pri);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_action       <= act;
    in_node_x       <= x;
    in_node_y       <= y;
    in_new_priority <= pri;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int fill_bias);
    logic [1:0]  act;
    logic [15:0] x, y;
    logic [31:0] pri;
    int          pick;
    pick = $urandom_range(99);
    if (pick < fill_bias) act = ACT_ENQUEUE;
    else if (pick < 80) act = ACT_DEQUEUE;
    else if (pick < 97) act = ACT_CHANGE;
    else act = ACT_NONE;
    if ($urandom_range(3) == 0) begin
      x = 16'($urandom); y = 16'($urandom);
    end else begin
      x = key_pool[$urandom_range(7)]; y = key_pool[$urandom_range(7)];
    end
    case ($urandom_range(3))
      0: pri = $urandom;
      1: pri = $urandom_range(7);
      2: pri = {16'($urandom_range(15)), 16'h0};
      default: pri = $urandom_range(31) == 0 ? 32'hFFFF_FFFF : $urandom_range(255);
    endcase
    send_request(act, x, y, pri);
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    key_pool[0] = 16'h8000;
    key_pool[1] = 16'h7FFF;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty dequeue, extremes, ties, change with and without a match.
    send_request(ACT_DEQUEUE, 16'h0, 16'h0, 32'h0);
    send_request(ACT_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ACT_ENQUEUE, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    send_request(ACT_ENQUEUE, 16'h7FFF, 16'h8000, 32'h0);
    send_request(ACT_ENQUEUE, 16'h0001, 16'h0002, 32'h5);
    send_request(ACT_ENQUEUE, 16'h0003, 16'h0004, 32'h5);
    send_request(ACT_CHANGE, 16'h8000, 16'h7FFF, 32'h1);
    send_request(ACT_CHANGE, 16'h1234, 16'h4321, 32'h5);
    send_request(ACT_ENQUEUE, 16'h0001, 16'h0002, 32'h2);
    send_request(ACT_CHANGE, 16'h0001, 16'h0002, 32'hA);
    repeat (7) send_request(ACT_DEQUEUE, 16'hFFFF, 16'h0, 32'h0);
    // Fill beyond capacity, then drops and a missing-key change when full.
    for (int i = 0; i < CAPACITY + 2; i++)
      send_request(ACT_ENQUEUE, 16'(i), 16'(~i), 32'($urandom_range(3)));
    send_request(ACT_CHANGE, 16'h5555, 16'hAAAA, 32'h0);
    send_request(ACT_CHANGE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (CAPACITY + 1) send_request(ACT_DEQUEUE, 16'h0, 16'h0, 32'h0);

    // Random phases: no idling, heavy idling, light idling, then no idling with more enqueues.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 70 : (ph == 2) ? 23 : 0;
      for (int n = 0; n < 240; n++)
        send_random((ph == 3) ? 60 : 45);
    end

    start    <= 1'b0;
    idle_pct = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("sorted_priority_queue_core regression: pass");
    else
      $display("sorted_priority_queue_core regression: fail");
    $finish;
  end

endmodule
